// File: design/led_comet_brightness_macros.svh
// Assertion macros used by the LED comet brightness checker.
`ifndef LED_COMET_BRIGHTNESS_MACROS_SVH
`define LED_COMET_BRIGHTNESS_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define LED_CMT_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("led comet check failed");

// Next-cycle implication.
`define LED_CMT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("led comet check failed");

// Implication after a fixed number of cycles.
`define LED_CMT_ASSERT_DELAY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error("led comet check failed");

`endif

// File: design/led_cmt_pkg.sv
// Package: field widths, register map and constants of the LED comet brightness block.
`timescale 1ns / 1ps

package led_cmt_pkg;

    // request fields
    localparam int FRAME_W        = 16;
    localparam int LED_POS_W      = 6;
    localparam int GROUP_SIZE_W   = 7;
    localparam int GROUP_OFFSET_W = 10;
    localparam int LED_ID_W       = 8;
    localparam int LEVEL_W        = 8;

    // configuration
    localparam int ZONE_RADIUS_W  = 8;
    localparam int RADIUS_FRAC    = 4;
    localparam int MS_PER_LED_W   = 14;
    localparam int SEQ_LEN_W      = 10;
    localparam int PADDR_W        = 5;
    localparam int APB_DW         = 32;
    localparam int REG_IDX_W      = 3;

    localparam logic [ZONE_RADIUS_W-1:0] ZONE_RADIUS_RST = 8'd48;
    localparam logic [MS_PER_LED_W-1:0]  MS_PER_LED_RST  = 14'd200;
    localparam logic                     SERIES_MODE_RST = 1'b0;
    localparam logic                     SMOOTH_RST      = 1'b1;
    localparam logic [SEQ_LEN_W-1:0]     SEQ_LEN_RST     = 10'd32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ZONE_RADIUS  = 3'd0,
        REG_MS_PER_LED   = 3'd1,
        REG_SERIES_MODE  = 3'd2,
        REG_SMOOTH_EDGES = 3'd3,
        REG_SEQ_LENGTH   = 3'd4
    } t_reg_idx;

    // internal widths
    localparam int SEQ_W      = 12;  // signed sequence index, -64 .. 1086
    localparam int FRAME20_W  = 21;  // frame * 20 (ms)
    localparam int TOTAL_W    = 11;  // sequence length plus edge padding
    localparam int LASTX_W    = 25;  // (total - 1) * ms_per_led, up to 1053 * 16383

    localparam int MS_PER_FRAME = 20;   // 50 frames per second
    localparam int LEVEL_SCALE  = 10;
    localparam int LEVEL_MAX    = 255;

endpackage

// File: design/led_cmt_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband that rides along.
`timescale 1ns / 1ps

module led_cmt_div #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 8,
    parameter int SB_W  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output logic [SB_W-1:0]  o_sb
);

    // stage k holds the dividend shifted k bits, low k bits already quotient
    logic [NUM_W:0]   r_vld;
    logic [NUM_W-1:0] r_q   [0:NUM_W];
    logic [DEN_W-1:0] r_rem [0:NUM_W];
    logic [DEN_W-1:0] r_den [0:NUM_W];
    logic [SB_W-1:0]  r_sb  [0:NUM_W];

    logic [DEN_W:0]   w_sh  [0:NUM_W-1];
    logic             w_ge  [0:NUM_W-1];
    logic [NUM_W-1:0] n_q   [1:NUM_W];
    logic [DEN_W-1:0] n_rem [1:NUM_W];

    always_comb begin
        for (int k = 0; k < NUM_W; k++) begin
            w_sh[k]    = {r_rem[k], r_q[k][NUM_W-1]};
            w_ge[k]    = (w_sh[k] >= {1'b0, r_den[k]});
            n_rem[k+1] = w_ge[k] ? DEN_W'(w_sh[k] - {1'b0, r_den[k]}) : w_sh[k][DEN_W-1:0];
            n_q[k+1]   = {r_q[k][NUM_W-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NUM_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0]   <= i_num;
        r_rem[0] <= '0;
        r_den[0] <= i_den;
        r_sb[0]  <= i_sb;
        for (int k = 0; k < NUM_W; k++) begin
            r_q[k+1]   <= n_q[k+1];
            r_rem[k+1] <= n_rem[k+1];
            r_den[k+1] <= r_den[k];
            r_sb[k+1]  <= r_sb[k];
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quo   = r_q[NUM_W];
    assign o_sb    = r_sb[NUM_W];

endmodule

// File: design/led_comet_brightness.sv
// Top level: LED comet brightness pipeline with its APB register file.
`timescale 1ns / 1ps

// LED comet brightness. Each request asks for the red and green drive levels of
// one LED in one frame of a comet sweeping along chained or parallel LED groups.
// A request is taken on any clock edge with start high; busy is always low, so a
// new request may enter every cycle. There is no flow control on the result side:
// o_strobe marks the one cycle in which each result sits on the o_ ports, and the
// receiver must take it then. Results come out in request order. The pipeline
// holds two bit-per-stage dividers, comet head position (frame*20*2^FRAC_BITS /
// ms_per_led) and red share (brightness * doubled distance from the group middle /
// (group size - 1)), then stages of adds, compares and output registers. The
// block holds no per-LED state, and needs no warm-up after reset. Registers
// (byte address 4*index): zone_radius, ms_per_led, series_mode, smooth_edges,
// sequence_length; write them only while no request is in flight. Reads return
// the stored value, unmapped addresses read zero. ms_per_led of zero acts as
// one; groups of one LED get no red.
module led_comet_brightness #(
    parameter int MAX_GROUP_SIZE = 64,
    parameter int FRAC_BITS      = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // APB register port
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [led_cmt_pkg::PADDR_W-1:0]           paddr,
    input  logic [led_cmt_pkg::APB_DW-1:0]            pwdata,
    output logic [led_cmt_pkg::APB_DW-1:0]            prdata,
    output logic                                      pready,
    // request
    input  logic                                      start,
    output logic                                      busy,
    input  logic [led_cmt_pkg::FRAME_W-1:0]           i_frame,
    input  logic [led_cmt_pkg::LED_POS_W-1:0]         i_led_pos,
    input  logic [led_cmt_pkg::GROUP_SIZE_W-1:0]      i_group_size,
    input  logic                                      i_group_reverse,
    input  logic [led_cmt_pkg::GROUP_OFFSET_W-1:0]    i_group_offset,
    input  logic [led_cmt_pkg::LED_ID_W-1:0]          i_led_id,
    // result
    output logic                                      o_strobe,
    output logic [led_cmt_pkg::LED_ID_W-1:0]          o_led_out_id,
    output logic [led_cmt_pkg::LEVEL_W-1:0]           o_red_level,
    output logic [led_cmt_pkg::LEVEL_W-1:0]           o_green_level,
    output logic                                      o_last_frame
);

    import led_cmt_pkg::*;

    localparam int SIZE_W  = $clog2(MAX_GROUP_SIZE) + 1;
    localparam int DEN2_W  = $clog2(MAX_GROUP_SIZE);
    localparam int NUMB_W  = (DEN2_W > LED_POS_W + 1) ? DEN2_W : LED_POS_W + 1;
    localparam int ND_W    = NUMB_W + 1;
    localparam int Q1_W    = FRAME20_W + FRAC_BITS;
    localparam int DIST_W  = Q1_W + 2;
    localparam int RAD_W   = ZONE_RADIUS_W + FRAC_BITS - RADIUS_FRAC;
    localparam int PROD_W  = RAD_W + NUMB_W;
    localparam int RED10_W = PROD_W + 4;
    localparam int GRN10_W = RAD_W + 4;
    // edges from request to result; the bound checker picks this up
    localparam int LATENCY = Q1_W + PROD_W + 7;

    typedef struct packed {
        logic [LED_ID_W-1:0]  id;
        logic [FRAME20_W-1:0] frame20;
    } t_tail;

    typedef struct packed {
        logic [NUMB_W-1:0] num;
        logic [DEN2_W-1:0] den;
        logic              den_ok;
        t_tail             tail;
    } t_mid;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        t_mid             mid;
    } t_sb1;

    typedef struct packed {
        logic [RAD_W-1:0] bright;
        t_tail            tail;
    } t_sb2;

    // ---------------- registers ----------------
    logic [ZONE_RADIUS_W-1:0] r_zone_radius;
    logic [MS_PER_LED_W-1:0]  r_ms_per_led;
    logic                     r_series;
    logic                     r_smooth;
    logic [SEQ_LEN_W-1:0]     r_seq_len;

    logic                     w_cfg_wr;
    logic [REG_IDX_W-1:0]     w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_radius <= ZONE_RADIUS_RST;
            r_ms_per_led  <= MS_PER_LED_RST;
            r_series      <= SERIES_MODE_RST;
            r_smooth      <= SMOOTH_RST;
            r_seq_len     <= SEQ_LEN_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_ZONE_RADIUS:  r_zone_radius <= pwdata[ZONE_RADIUS_W-1:0];
                REG_MS_PER_LED:   r_ms_per_led  <= pwdata[MS_PER_LED_W-1:0];
                REG_SERIES_MODE:  r_series      <= pwdata[0];
                REG_SMOOTH_EDGES: r_smooth      <= pwdata[0];
                REG_SEQ_LENGTH:   r_seq_len     <= pwdata[SEQ_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_ZONE_RADIUS:  prdata = APB_DW'(r_zone_radius);
            REG_MS_PER_LED:   prdata = APB_DW'(r_ms_per_led);
            REG_SERIES_MODE:  prdata = APB_DW'(r_series);
            REG_SMOOTH_EDGES: prdata = APB_DW'(r_smooth);
            REG_SEQ_LENGTH:   prdata = APB_DW'(r_seq_len);
            default:          prdata = '0;
        endcase
    end

    // ---------------- values derived from registers ----------------
    // User must move registers only while nothing is in flight, unenforced; read directly.
    logic [MS_PER_LED_W-1:0] w_ms;
    logic [RAD_W-1:0]        w_rad;
    logic [RAD_W-1:0]        w_rad_off;
    logic [TOTAL_W-1:0]      w_total;
    logic [TOTAL_W-1:0]      w_total_m1;
    logic [LASTX_W-1:0]      r_last_x;
    logic                    r_total_nz;

    assign w_ms       = (r_ms_per_led == '0) ? MS_PER_LED_W'(1) : r_ms_per_led;
    assign w_rad      = RAD_W'(r_zone_radius) << (FRAC_BITS - RADIUS_FRAC);
    assign w_rad_off  = r_smooth ? w_rad : '0;
    assign w_total    = TOTAL_W'(r_seq_len)
                      + (r_smooth ? TOTAL_W'(r_zone_radius >> 3) : '0);
    assign w_total_m1 = w_total - TOTAL_W'(1);

    // x = (total - 1) * ms_per_led: the frame matches when 20*frame lands in [x-19, x]
    always_ff @(posedge i_clk) begin
        r_last_x   <= LASTX_W'(w_total_m1) * LASTX_W'(w_ms);
        r_total_nz <= (w_total != '0);
    end

    // ---------------- request entry ----------------
    logic                 w_accept;
    logic [SIZE_W-1:0]    w_size;
    logic                 w_den_ok;
    logic [DEN2_W-1:0]    w_den;
    logic [SEQ_W-1:0]     w_seq_rev;
    logic [SEQ_W-1:0]     w_seq;
    logic [ND_W-1:0]      w_nd;
    logic [NUMB_W-1:0]    w_num;
    logic [FRAME20_W-1:0] w_frame20;
    t_sb1                 w_sb1_in;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    assign w_size    = (int'(i_group_size) > MAX_GROUP_SIZE) ? SIZE_W'(MAX_GROUP_SIZE)
                                                             : SIZE_W'(i_group_size);
    assign w_den_ok  = (w_size > SIZE_W'(1));
    assign w_den     = DEN2_W'(w_size - SIZE_W'(1));
    // sequence index may go negative for a reversed LED outside its group
    assign w_seq_rev = SEQ_W'(w_size) - SEQ_W'(1) - SEQ_W'(i_led_pos);
    assign w_seq     = (i_group_reverse ? w_seq_rev : SEQ_W'(i_led_pos))
                     + (r_series ? SEQ_W'(i_group_offset) : '0);
    // distance from group middle, doubled: |2*pos - (n-1)|
    assign w_nd      = ND_W'({i_led_pos, 1'b0}) - ND_W'(w_den);
    assign w_num     = w_nd[ND_W-1] ? NUMB_W'(-w_nd) : NUMB_W'(w_nd);
    assign w_frame20 = FRAME20_W'({i_frame, 4'b0000}) + FRAME20_W'({i_frame, 2'b00});

    assign w_sb1_in.seq              = w_seq;
    assign w_sb1_in.mid.num          = w_num;
    assign w_sb1_in.mid.den          = w_den;
    assign w_sb1_in.mid.den_ok       = w_den_ok;
    assign w_sb1_in.mid.tail.id      = i_led_id;
    assign w_sb1_in.mid.tail.frame20 = w_frame20;

    // ---------------- head position divider ----------------
    logic             w_d1_vld;
    logic [Q1_W-1:0]  w_head;
    t_sb1             w_sb1_out;

    led_cmt_div #(
        .NUM_W (Q1_W),
        .DEN_W (MS_PER_LED_W),
        .SB_W  ($bits(t_sb1))
    ) u_head_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_num   ({w_frame20, {FRAC_BITS{1'b0}}}),
        .i_den   (w_ms),
        .i_sb    (w_sb1_in),
        .o_valid (w_d1_vld),
        .o_quo   (w_head),
        .o_sb    (w_sb1_out)
    );

    // ---------------- distance and brightness ----------------
    logic              r_p1_vld, r_p2_vld, r_p3_vld;
    logic [DIST_W-1:0] r_p1_dist;
    logic [DIST_W-1:0] r_p2_abs;
    logic [RAD_W-1:0]  r_p3_bright;
    t_mid              r_p1_mid, r_p2_mid, r_p3_mid;
    logic [DIST_W-1:0] w_seq_x;
    logic [DIST_W-1:0] w_rad_x;

    assign w_seq_x = {{(DIST_W - SEQ_W){w_sb1_out.seq[SEQ_W-1]}}, w_sb1_out.seq};
    assign w_rad_x = DIST_W'(w_rad);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else begin
            r_p1_vld <= w_d1_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // seq*one - (head - rad), rad only with smooth edges
        r_p1_dist   <= (w_seq_x << FRAC_BITS) + DIST_W'(w_rad_off) - DIST_W'(w_head);
        r_p1_mid    <= w_sb1_out.mid;
        r_p2_abs    <= r_p1_dist[DIST_W-1] ? -r_p1_dist : r_p1_dist;
        r_p2_mid    <= r_p1_mid;
        r_p3_bright <= (r_p2_abs < w_rad_x) ? RAD_W'(w_rad_x - r_p2_abs) : '0;
        r_p3_mid    <= r_p2_mid;
    end

    // ---------------- red share divider ----------------
    logic [PROD_W-1:0] w_prod;
    logic [DEN2_W-1:0] w_den2;
    t_sb2              w_sb2_in;
    logic              w_d2_vld;
    logic [PROD_W-1:0] w_red;
    t_sb2              w_sb2_out;

    // one-LED group: 0 / 1 gives no red
    assign w_prod = r_p3_mid.den_ok ? PROD_W'(r_p3_bright) * PROD_W'(r_p3_mid.num) : '0;
    assign w_den2 = r_p3_mid.den_ok ? r_p3_mid.den : DEN2_W'(1);
    assign w_sb2_in.bright = r_p3_bright;
    assign w_sb2_in.tail   = r_p3_mid.tail;

    led_cmt_div #(
        .NUM_W (PROD_W),
        .DEN_W (DEN2_W),
        .SB_W  ($bits(t_sb2))
    ) u_red_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p3_vld),
        .i_num   (w_prod),
        .i_den   (w_den2),
        .i_sb    (w_sb2_in),
        .o_valid (w_d2_vld),
        .o_quo   (w_red),
        .o_sb    (w_sb2_out)
    );

    // ---------------- green share ----------------
    logic              r_p5_vld;
    logic [PROD_W-1:0] r_p5_red;
    logic [RAD_W-1:0]  r_p5_green;
    t_tail             r_p5_tail;
    logic [PROD_W-1:0] w_bright_x;

    assign w_bright_x = PROD_W'(w_sb2_out.bright);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_vld <= 1'b0;
        end else begin
            r_p5_vld <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p5_red   <= w_red;
        // red above brightness (LED outside its group) leaves green dark
        r_p5_green <= (w_red < w_bright_x) ? RAD_W'(w_bright_x - w_red) : '0;
        r_p5_tail  <= w_sb2_out.tail;
    end

    // ---------------- levels, last frame, output register ----------------
    logic [RED10_W-1:0]  w_red10;
    logic [GRN10_W-1:0]  w_grn10;
    logic [RED10_W-1:0]  w_red_sh;
    logic [GRN10_W-1:0]  w_grn_sh;
    logic [LEVEL_W-1:0]  w_red_lvl;
    logic [LEVEL_W-1:0]  w_grn_lvl;
    logic [LASTX_W:0]    w_ldiff;
    logic                w_last;

    assign w_red10   = RED10_W'(r_p5_red) * RED10_W'(LEVEL_SCALE);
    assign w_grn10   = GRN10_W'(r_p5_green) * GRN10_W'(LEVEL_SCALE);
    assign w_red_sh  = w_red10 >> FRAC_BITS;
    assign w_grn_sh  = w_grn10 >> FRAC_BITS;
    assign w_red_lvl = (w_red_sh > RED10_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                        : w_red_sh[LEVEL_W-1:0];
    assign w_grn_lvl = (w_grn_sh > GRN10_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                        : w_grn_sh[LEVEL_W-1:0];

    assign w_ldiff = (LASTX_W + 1)'(r_last_x) - (LASTX_W + 1)'(r_p5_tail.frame20);
    assign w_last  = r_total_nz && !w_ldiff[LASTX_W]
                  && (w_ldiff < (LASTX_W + 1)'(MS_PER_FRAME));

    logic                r_out_vld;
    logic [LED_ID_W-1:0] r_out_id;
    logic [LEVEL_W-1:0]  r_out_red;
    logic [LEVEL_W-1:0]  r_out_green;
    logic                r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_p5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_id    <= r_p5_tail.id;
        r_out_red   <= w_red_lvl;
        r_out_green <= w_grn_lvl;
        r_out_last  <= w_last;
    end

    assign o_strobe      = r_out_vld;
    assign o_led_out_id  = r_out_id;
    assign o_red_level   = r_out_red;
    assign o_green_level = r_out_green;
    assign o_last_frame  = r_out_last;

endmodule

// File: design/led_cmt_chk.sv
// Checker for the LED comet brightness ports, with its bind to the top level.
`timescale 1ns / 1ps
`include "led_comet_brightness_macros.svh"

module led_cmt_chk #(
    parameter int LATENCY = 1
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [led_cmt_pkg::PADDR_W-1:0] paddr,
    input logic [led_cmt_pkg::APB_DW-1:0]  pwdata,
    input logic [led_cmt_pkg::APB_DW-1:0]  prdata,
    input logic                            pready,
    input logic                            start,
    input logic                            busy,
    input logic                            o_strobe
);

    import led_cmt_pkg::*;

    // every request yields its result a fixed number of cycles later
    `LED_CMT_ASSERT_DELAY(a_request_gives_result, start && !busy, LATENCY, o_strobe)

    // no result without a request that far back
    `LED_CMT_ASSERT_IMPLY(a_result_has_request, o_strobe, $past(start && !busy, LATENCY))

    // zone radius reads back what was just written
    `LED_CMT_ASSERT_NEXT(a_radius_readback, psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == REG_ZONE_RADIUS), (paddr != $past(paddr)) || (prdata == APB_DW'($past(pwdata[ZONE_RADIUS_W-1:0]))))

endmodule

bind led_comet_brightness led_cmt_chk #(.LATENCY(LATENCY)) u_chk (.*);

// File: bench/led_comet_brightness_tb.sv
// Testbench for the LED comet brightness block: predictor, request driver and result checker.
`timescale 1ns / 1ps

// Requests are queued by the stimulus process and presented by a driver at the
// falling clock edge. A request counts as taken at the rising edge with start
// high and busy low. The expected levels are predicted there, with the register
// settings held in this bench. Results cannot be stalled, so every strobe is
// checked against the oldest prediction in the same rising edge.
module led_comet_brightness_tb;
    import led_cmt_pkg::*;

    localparam int FRAC           = 8;
    localparam int MAX_GROUP      = 64;
    localparam int LATENCY        = 2 * FRAC + 32 + 7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 8;
    localparam int PHASE_REQUESTS = 156;

    typedef struct packed {
        logic [FRAME_W-1:0]        frame;
        logic [LED_POS_W-1:0]      led_pos;
        logic [GROUP_SIZE_W-1:0]   group_size;
        logic                      group_reverse;
        logic [GROUP_OFFSET_W-1:0] group_offset;
        logic [LED_ID_W-1:0]       led_id;
    } t_led_query;

    typedef struct packed {
        logic [LED_ID_W-1:0] led_out_id;
        logic [LEVEL_W-1:0]  red_level;
        logic [LEVEL_W-1:0]  green_level;
        logic                last_frame;
    } t_led_levels;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                start = 1'b0;
    logic                busy;
    logic                o_strobe;
    logic [LED_ID_W-1:0] o_led_out_id;
    logic [LEVEL_W-1:0]  o_red_level;
    logic [LEVEL_W-1:0]  o_green_level;
    logic                o_last_frame;

    // request on the ports, updated by the driver only
    t_led_query cur_query = '0;

    // register copy, kept in step with every write
    longint cfg_radius  = longint'(ZONE_RADIUS_RST);
    longint cfg_ms      = longint'(MS_PER_LED_RST);
    longint cfg_series  = longint'(SERIES_MODE_RST);
    longint cfg_smooth  = longint'(SMOOTH_RST);
    longint cfg_seq_len = longint'(SEQ_LEN_RST);

    t_led_query  led_query_q[$];
    t_led_levels expected_levels_q[$];

    bit     req_taken = 1'b0;
    int     send_idle_pct = 0;
    int     idle_cycles = 0;
    int     mismatch_count = 0;
    int     requests_taken = 0;
    int     settings_run = 1;
    int     lit_red = 0;
    int     lit_green = 0;
    int     last_flags = 0;

    led_comet_brightness #(
        .MAX_GROUP_SIZE(MAX_GROUP),
        .FRAC_BITS     (FRAC)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_frame        (cur_query.frame),
        .i_led_pos      (cur_query.led_pos),
        .i_group_size   (cur_query.group_size),
        .i_group_reverse(cur_query.group_reverse),
        .i_group_offset (cur_query.group_offset),
        .i_led_id       (cur_query.led_id),
        .o_strobe       (o_strobe),
        .o_led_out_id   (o_led_out_id),
        .o_red_level    (o_red_level),
        .o_green_level  (o_green_level),
        .o_last_frame   (o_last_frame)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // ms_per_led of zero behaves as one
    function automatic longint eff_ms();
        return (cfg_ms == 0) ? 1 : cfg_ms;
    endfunction

    // comet half width at the internal fraction width
    function automatic longint radius_fx();
        return cfg_radius << (FRAC - RADIUS_FRAC);
    endfunction

    // frame that closes the pass, -1 for an empty sequence
    function automatic longint final_frame();
        longint total;
        total = cfg_seq_len + (cfg_smooth != 0 ? (2 * cfg_radius) >> 4 : 0);
        if (total == 0)
            return -1;
        return (total - 1) * eff_ms() * 50 / 1000;
    endfunction

    function automatic logic [LEVEL_W-1:0] drive_level(longint share);
        longint v;
        if (share <= 0)
            return '0;
        v = (share * LEVEL_SCALE) >> FRAC;
        return (v > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(v);
    endfunction

    function automatic t_led_levels comet_levels(t_led_query q);
        longint size_v, pos_v, seq_v, head, gap, bright, red, den, num, final_fr;
        t_led_levels r;
        size_v = longint'(q.group_size);
        if (size_v > MAX_GROUP)
            size_v = MAX_GROUP;
        pos_v = longint'(q.led_pos);
        head = (longint'(q.frame) * MS_PER_FRAME * (longint'(1) << FRAC)) / eff_ms();
        if (cfg_smooth != 0)
            head -= radius_fx();
        seq_v = q.group_reverse ? size_v - 1 - pos_v : pos_v;
        if (cfg_series != 0)
            seq_v += longint'(q.group_offset);
        gap = (seq_v << FRAC) - head;
        if (gap < 0)
            gap = -gap;
        bright = radius_fx() - gap;
        if (bright < 0)
            bright = 0;
        // red grows toward the group ends; a one-LED group has no middle
        den = size_v - 1;
        if (den <= 0) begin
            red = 0;
        end else begin
            num = 2 * pos_v - den;
            if (num < 0)
                num = -num;
            red = (bright * num) / den;
        end
        final_fr = final_frame();
        r.led_out_id  = q.led_id;
        r.red_level   = drive_level(red);
        r.green_level = drive_level(bright - red);
        r.last_frame  = (final_fr >= 0) && (longint'(q.frame) == final_fr);
        return r;
    endfunction

    // Mostly requests aimed at the lit zone of the comet, some on the closing
    // frame, the rest full-range noise.
    function automatic t_led_query random_query();
        t_led_query q;
        longint size_v, seq_v, center, spread, final_fr;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        q.led_id        = LED_ID_W'($urandom_range(0, 255));
        q.group_reverse = 1'($urandom_range(0, 1));
        q.group_offset  = GROUP_OFFSET_W'($urandom_range(0, 1023));
        if (pick < 15) begin
            q.frame      = FRAME_W'($urandom_range(0, 65535));
            q.led_pos    = LED_POS_W'($urandom_range(0, 63));
            q.group_size = GROUP_SIZE_W'($urandom_range(0, 127));
            return q;
        end
        q.group_size = GROUP_SIZE_W'($urandom_range(1, MAX_GROUP));
        if ($urandom_range(0, 9) == 0)
            q.led_pos = LED_POS_W'($urandom_range(0, 63));
        else
            q.led_pos = LED_POS_W'($urandom_range(0, q.group_size - 1));
        if (cfg_series != 0 && pick < 60)
            q.group_offset = GROUP_OFFSET_W'($urandom_range(0, cfg_seq_len));
        size_v = longint'(q.group_size);
        seq_v = q.group_reverse ? size_v - 1 - longint'(q.led_pos) : longint'(q.led_pos);
        if (cfg_series != 0)
            seq_v += longint'(q.group_offset);
        // frame at which the comet head sits on this LED, plus jitter of a radius
        center = ((seq_v << FRAC) + (cfg_smooth != 0 ? radius_fx() : 0)) * eff_ms()
                 / (MS_PER_FRAME << FRAC);
        spread = radius_fx() * eff_ms() / (MS_PER_FRAME << FRAC) + 2;
        center += longint'($urandom_range(0, 2 * spread)) - spread;
        final_fr = final_frame();
        if (pick < 25 && final_fr >= 0 && final_fr <= 65535)
            center = final_fr;
        if (center < 0)
            center = 0;
        if (center > 65535)
            center = 65535;
        q.frame = FRAME_W'(center);
        return q;
    endfunction

    task automatic add_query(int frame, int pos, int size, int rev, int offset, int id);
        t_led_query q;
        q.frame         = FRAME_W'(frame);
        q.led_pos       = LED_POS_W'(pos);
        q.group_size    = GROUP_SIZE_W'(size);
        q.group_reverse = 1'(rev);
        q.group_offset  = GROUP_OFFSET_W'(offset);
        q.led_id        = LED_ID_W'(id);
        led_query_q.push_back(q);
    endtask

    task automatic queue_random(int count);
        @(posedge i_clk);
        repeat (count)
            led_query_q.push_back(random_query());
    endtask

    // sender side pause: nothing pending, nothing presented, nothing in flight
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (led_query_q.size() != 0 || start || expected_levels_q.size() != 0);
    endtask

    task automatic reg_write(t_reg_idx idx, longint value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ZONE_RADIUS:  cfg_radius  = value & 'hFF;
            REG_MS_PER_LED:   cfg_ms      = value & 'h3FFF;
            REG_SERIES_MODE:  cfg_series  = value & 1;
            REG_SMOOTH_EDGES: cfg_smooth  = value & 1;
            REG_SEQ_LENGTH:   cfg_seq_len = value & 'h3FF;
            default: ;
        endcase
    endtask

    task automatic set_comet(longint radius, longint ms, longint series, longint smooth,
                             longint seq_len);
        reg_write(REG_ZONE_RADIUS, radius);
        reg_write(REG_MS_PER_LED, ms);
        reg_write(REG_SERIES_MODE, series);
        reg_write(REG_SMOOTH_EDGES, smooth);
        reg_write(REG_SEQ_LENGTH, seq_len);
        settings_run++;
    endtask

    // Driver: presents the next request once the current one is taken,
    // idling at random by the current percentage.
    always @(negedge i_clk) begin
        if (!start || req_taken) begin
            if (led_query_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_query <= led_query_q.pop_front();
                start     <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Monitor: predicts taken requests, checks strobed results, runs the watchdog.
    always @(posedge i_clk) begin
        t_led_levels want;
        if (!i_rst_n) begin
            req_taken   = 1'b0;
            idle_cycles = 0;
        end else begin
            req_taken = start && !busy;
            if (req_taken) begin
                expected_levels_q.push_back(comet_levels(cur_query));
                requests_taken++;
            end
            if (o_strobe) begin
                if (expected_levels_q.size() == 0) begin
                    $display("%0t: result with none expected, actual id %0d", $time,
                             o_led_out_id);
                    mismatch_count++;
                end else begin
                    want = expected_levels_q.pop_front();
                    check_field("led_out_id", want.led_out_id, o_led_out_id);
                    check_field("red_level", want.red_level, o_red_level);
                    check_field("green_level", want.green_level, o_green_level);
                    check_field("last_frame", want.last_frame, o_last_frame);
                    if (want.red_level != 0)
                        lit_red++;
                    if (want.green_level != 0)
                        lit_green++;
                    if (want.last_frame)
                        last_flags++;
                end
            end
            if (req_taken || o_strobe)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int idle_pattern[3];
        idle_pattern = '{0, 57, 25};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed requests at reset settings: head on LED 10 near frame 130,
        // closing frame 370
        @(posedge i_clk);
        add_query(0, 0, 1, 0, 0, 0);            // one-LED group
        add_query(130, 0, 0, 0, 0, 1);          // empty group
        add_query(130, 63, 127, 0, 0, 2);       // oversized group
        add_query(130, 63, 64, 1, 1023, 3);
        add_query(130, 0, 64, 0, 0, 4);
        add_query(130, 10, 21, 0, 0, 5);        // middle LED, no red
        add_query(130, 0, 21, 1, 0, 6);         // end LED, all red
        add_query(125, 5, 21, 1, 0, 7);
        add_query(136, 10, 2, 0, 0, 8);
        add_query(136, 1, 2, 1, 0, 9);
        add_query(130, 63, 4, 0, 0, 10);        // LED outside its group
        add_query(130, 40, 12, 1, 0, 11);       // outside, reversed
        add_query(370, 3, 8, 0, 0, 12);         // closing frame
        add_query(369, 3, 8, 0, 0, 13);
        add_query(65535, 63, 127, 1, 1023, 255);
        add_query(0, 0, 0, 0, 0, 0);
        add_query(65535, 0, 64, 0, 0, 128);
        add_query(60, 0, 32, 0, 0, 64);
        add_query(180, 31, 32, 0, 0, 32);
        add_query(180, 31, 32, 1, 0, 16);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_comet(255, 1, 1, 1, 1023);
                1: set_comet(0, 16383, 0, 0, 1);
                2: set_comet(48, 0, 0, 0, 0);        // ms zero, empty sequence
                3: set_comet(200, 37, 1, 0, 300);
                4: set_comet(16, 5, 0, 1, 64);
                default: set_comet($urandom_range(0, 255),
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16383)
                                                               : $urandom_range(1, 400),
                                   $urandom_range(0, 1), $urandom_range(0, 1),
                                   $urandom_range(1, 1023));
            endcase
            send_idle_pct = idle_pattern[p % 3];
            // split each phase with a full drain so the sender sees an empty pipe
            queue_random(PHASE_REQUESTS / 2);
            wait_drained();
            queue_random(PHASE_REQUESTS - PHASE_REQUESTS / 2);
            wait_drained();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (expected_levels_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_levels_q.size());
            mismatch_count += expected_levels_q.size();
        end
        $display("covered %0d LED requests over %0d register settings", requests_taken,
                 settings_run);
        $display("lit results: %0d red, %0d green; %0d closing-frame flags", lit_red,
                 lit_green, last_flags);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/led_cmt_pkg.sv
design/led_cmt_div.sv
design/led_comet_brightness.sv
design/led_cmt_chk.sv
bench/led_comet_brightness_tb.sv
